[rtl/pamc_pkg.sv]
package pamc_pkg;

  localparam int COEF_W = 16;
  localparam int WORD_W = 32;
  localparam int PROD_W = COEF_W + WORD_W;
  localparam int SUM_W = PROD_W + 3;
  localparam int DOT_W = 17;
  localparam int BOUND_W = 15;
  localparam int IDX_W = 8;
  localparam int FUNC_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_HALF = 8192;

  localparam int MAX_MAP_PLANES_DEF = 256;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [WORD_W-1:0] DIST_START = WORD_W'(100 * 65536);
  localparam logic signed [DOT_W-1:0] DOT_HI = DOT_W'(65535);
  localparam logic signed [DOT_W-1:0] DOT_LO = DOT_W'(-65536);
  localparam logic [BOUND_W-1:0] BOUND_MAX = '1;
  localparam logic [IDX_W-1:0] COUNT_MAX = '1;

  localparam logic [FUNC_W-1:0] FUNC_BEGIN = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_HEADER = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POINT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_END = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FINISH = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERPENDICULAR_LIMIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARALLEL_LIMIT = 2'd3;

  localparam int FLAG_MATCH = 0;
  localparam int FLAG_PARALLEL = 1;
  localparam int FLAG_PERPENDICULAR = 2;

  typedef enum logic [2:0] {
    OP_BEGIN,
    OP_HEADER,
    OP_POINT,
    OP_END,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e op;
    logic flag;
    logic [2:0][COEF_W-1:0] coef;
    logic [2:0][WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] distance_limit;
    logic [BOUND_W-1:0] angle_limit;
    logic [BOUND_W-1:0] perpendicular_limit;
    logic [BOUND_W-1:0] parallel_limit;
  } cfg_t;

endpackage

[rtl/pamc_intf.sv]
interface pamc_in_if;
  logic valid;
  logic ready;
  logic [2:0] func;
  logic new_frame;
  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic signed [15:0] coef_c;
  logic signed [31:0] coef_d;
  logic map_bad;
  logic signed [31:0] pt_x;
  logic signed [31:0] pt_y;
  logic signed [31:0] pt_z;

  modport source (
    output valid, func, new_frame, coef_a, coef_b, coef_c, coef_d, map_bad, pt_x, pt_y,
           pt_z,
    input  ready
  );
  modport sink (
    input  valid, func, new_frame, coef_a, coef_b, coef_c, coef_d, map_bad, pt_x, pt_y,
           pt_z,
    output ready
  );
endinterface

interface pamc_out_if;
  logic valid;
  logic ready;
  logic found;
  logic [7:0] match_index;
  logic parallel_valid;
  logic [7:0] parallel_index;
  logic perpendicular_valid;
  logic [7:0] perpendicular_index;
  logic [7:0] match_count;

  modport source (
    output valid, found, match_index, parallel_valid, parallel_index, perpendicular_valid,
           perpendicular_index, match_count,
    input  ready
  );
  modport sink (
    input  valid, found, match_index, parallel_valid, parallel_index, perpendicular_valid,
           perpendicular_index, match_count,
    output ready
  );
endinterface

[rtl/pamc_front.sv]
module pamc_front (
  pamc_in_if.sink      in_i,
  input  logic         full_i,
  output logic         push_o,
  output pamc_pkg::cmd_t push_cmd_o
);
  import pamc_pkg::*;

  logic known;

  always_comb begin
    push_cmd_o = '0;
    push_cmd_o.coef = {in_i.coef_c, in_i.coef_b, in_i.coef_a};
    known = 1'b1;
    unique case (in_i.func)
      FUNC_BEGIN: begin
        push_cmd_o.op = OP_BEGIN;
        push_cmd_o.flag = in_i.new_frame;
        push_cmd_o.word[0] = in_i.coef_d;
      end
      FUNC_HEADER: begin
        push_cmd_o.op = OP_HEADER;
        push_cmd_o.flag = in_i.map_bad;
      end
      FUNC_POINT: begin
        push_cmd_o.op = OP_POINT;
        push_cmd_o.flag = (in_i.pt_z != '0);
        push_cmd_o.word = {in_i.pt_z, in_i.pt_y, in_i.pt_x};
      end
      FUNC_END: begin
        push_cmd_o.op = OP_END;
      end
      FUNC_FINISH: begin
        push_cmd_o.op = OP_FINISH;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unknown requests are taken and dropped here.
  assign in_i.ready = !full_i;
  assign push_o = in_i.valid && !full_i && known;

endmodule

[rtl/pamc_fifo.sv]
module pamc_fifo #(
  parameter int Depth = pamc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pamc_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pamc_pkg::cmd_t head_o
);
  import pamc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("Queue fill count exceeds its depth.");

endmodule

[rtl/pamc_back.sv]
module pamc_back #(
  parameter int MaxMapPlanes = pamc_pkg::MAX_MAP_PLANES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pamc_pkg::cfg_t cfg_i,
  input  logic           head_valid_i,
  input  pamc_pkg::cmd_t head_cmd_i,
  output logic           pop_o,
  pamc_out_if.source     out_o
);
  import pamc_pkg::*;

  localparam int CntLimitInt = (MaxMapPlanes - 1 > 255) ? 255 : MaxMapPlanes - 1;
  localparam logic [IDX_W-1:0] CntLimit = IDX_W'(CntLimitInt);

  // Observed plane, written when a begin request issues.
  logic signed [COEF_W-1:0] obs_q [3];
  logic signed [WORD_W-1:0] obs_off_q;

  // Multiply stage.
  logic m_valid_q;
  op_e m_op_q;
  logic m_flag_q;
  logic signed [PROD_W-1:0] m_prod_q [3];
  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [WORD_W-1:0] opb [3];
  logic signed [WORD_W-1:0] m_off_q;

  // Sum stage.
  logic s_valid_q;
  op_e s_op_q;
  logic s_flag_q;
  logic signed [SUM_W-1:0] s_sum_q, s_sum_d;

  // Matcher state.
  logic signed [DOT_W-1:0] dot_q, dot_d;
  logic bad_q, bad_d;
  logic [WORD_W-1:0] min_q, min_d;
  logic [WORD_W-1:0] run_dist_q, run_dist_d;
  logic [BOUND_W-1:0] run_par_q, run_par_d;
  logic [BOUND_W-1:0] run_perp_q, run_perp_d;
  logic [2:0] flags_q, flags_d;
  logic [2:0][IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] map_cnt_q, map_cnt_d;
  logic [IDX_W-1:0] frame_q, frame_d;

  // Result register.
  logic out_valid_q;
  logic [2:0] out_flags_q;
  logic [2:0][IDX_W-1:0] out_idx_q;
  logic [IDX_W-1:0] out_count_q;

  logic en, exec, out_load;
  logic signed [SUM_W-1:0] dot_rnd;
  logic signed [DOT_W-1:0] dot_sat;
  logic [SUM_W-1:0] mag, dist_rnd;
  logic [WORD_W-1:0] dist_sat;
  logic [DOT_W-1:0] ad;
  logic [BOUND_W-1:0] ad_bound;

  // Only a finish request waiting on a full result register holds the pipe.
  assign en = !(s_valid_q && (s_op_q == OP_FINISH) && out_valid_q && !out_o.ready);
  assign exec = s_valid_q && en;
  assign pop_o = en && head_valid_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opb[i] = (head_cmd_i.op == OP_HEADER) ? WORD_W'($signed(head_cmd_i.coef[i]))
                                             : $signed(head_cmd_i.word[i]);
      prod_d[i] = PROD_W'(obs_q[i]) * PROD_W'(opb[i]);
    end
  end

  assign s_sum_d = SUM_W'(m_prod_q[0]) + SUM_W'(m_prod_q[1]) + SUM_W'(m_prod_q[2])
                 + (SUM_W'(m_off_q) <<< FRAC_SHIFT);

  always_comb begin
    dot_rnd = (s_sum_q + SUM_W'(ROUND_HALF)) >>> FRAC_SHIFT;
    priority if (dot_rnd > SUM_W'(DOT_HI)) begin
      dot_sat = DOT_HI;
    end else if (dot_rnd < SUM_W'(DOT_LO)) begin
      dot_sat = DOT_LO;
    end else begin
      dot_sat = dot_rnd[DOT_W-1:0];
    end

    mag = s_sum_q[SUM_W-1] ? SUM_W'(-s_sum_q) : SUM_W'(s_sum_q);
    dist_rnd = (mag + SUM_W'(ROUND_HALF)) >> FRAC_SHIFT;
    dist_sat = (|dist_rnd[SUM_W-1:WORD_W]) ? '1 : dist_rnd[WORD_W-1:0];

    ad = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);
    ad_bound = (ad > DOT_W'(BOUND_MAX)) ? BOUND_MAX : ad[BOUND_W-1:0];
  end

  always_comb begin
    dot_d = dot_q;
    bad_d = bad_q;
    min_d = min_q;
    run_dist_d = run_dist_q;
    run_par_d = run_par_q;
    run_perp_d = run_perp_q;
    flags_d = flags_q;
    idx_d = idx_q;
    map_cnt_d = map_cnt_q;
    frame_d = frame_q;
    out_load = 1'b0;
    if (exec) begin
      unique case (s_op_q)
        OP_BEGIN: begin
          if (s_flag_q) begin
            frame_d = '0;
          end
          run_dist_d = cfg_i.distance_limit;
          run_par_d = cfg_i.parallel_limit;
          run_perp_d = cfg_i.perpendicular_limit;
          flags_d = '0;
          idx_d = '0;
          map_cnt_d = '0;
        end
        OP_HEADER: begin
          dot_d = dot_sat;
          bad_d = s_flag_q;
          min_d = DIST_START;
        end
        OP_POINT: begin
          if (s_flag_q && (dist_sat < min_q)) begin
            min_d = dist_sat;
          end
        end
        OP_END: begin
          if (!bad_q) begin
            priority if ((ad > DOT_W'(cfg_i.angle_limit)) && (min_q < run_dist_q)) begin
              run_dist_d = min_q;
              flags_d[FLAG_MATCH] = 1'b1;
              idx_d[FLAG_MATCH] = map_cnt_q;
            end else if (ad > DOT_W'(run_par_q)) begin
              run_par_d = ad_bound;
              flags_d[FLAG_PARALLEL] = 1'b1;
              idx_d[FLAG_PARALLEL] = map_cnt_q;
            end else if (ad < DOT_W'(run_perp_q)) begin
              run_perp_d = ad_bound;
              flags_d[FLAG_PERPENDICULAR] = 1'b1;
              idx_d[FLAG_PERPENDICULAR] = map_cnt_q;
            end
          end
          if (map_cnt_q < CntLimit) begin
            map_cnt_d = map_cnt_q + 1'b1;
          end
        end
        OP_FINISH: begin
          if (flags_q[FLAG_MATCH] && (frame_q != COUNT_MAX)) begin
            frame_d = frame_q + 1'b1;
          end
          out_load = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        obs_q[i] <= '0;
      end
      obs_off_q <= '0;
      m_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      dot_q <= '0;
      bad_q <= 1'b0;
      min_q <= DIST_START;
      run_dist_q <= '0;
      run_par_q <= '0;
      run_perp_q <= '0;
      flags_q <= '0;
      idx_q <= '0;
      map_cnt_q <= '0;
      frame_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o && (head_cmd_i.op == OP_BEGIN)) begin
        for (int i = 0; i < 3; i++) begin
          obs_q[i] <= $signed(head_cmd_i.coef[i]);
        end
        obs_off_q <= $signed(head_cmd_i.word[0]);
      end
      if (en) begin
        m_valid_q <= head_valid_i;
        s_valid_q <= m_valid_q;
      end
      dot_q <= dot_d;
      bad_q <= bad_d;
      min_q <= min_d;
      run_dist_q <= run_dist_d;
      run_par_q <= run_par_d;
      run_perp_q <= run_perp_d;
      flags_q <= flags_d;
      idx_q <= idx_d;
      map_cnt_q <= map_cnt_d;
      frame_q <= frame_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_op_q <= head_cmd_i.op;
      m_flag_q <= head_cmd_i.flag;
      for (int i = 0; i < 3; i++) begin
        m_prod_q[i] <= prod_d[i];
      end
      m_off_q <= (head_cmd_i.op == OP_POINT) ? obs_off_q : '0;
      s_op_q <= m_op_q;
      s_flag_q <= m_flag_q;
      s_sum_q <= s_sum_d;
    end
    if (out_load) begin
      out_flags_q <= flags_q;
      out_idx_q <= idx_q;
      out_count_q <= frame_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.found = out_flags_q[FLAG_MATCH];
  assign out_o.match_index = out_idx_q[FLAG_MATCH];
  assign out_o.parallel_valid = out_flags_q[FLAG_PARALLEL];
  assign out_o.parallel_index = out_idx_q[FLAG_PARALLEL];
  assign out_o.perpendicular_valid = out_flags_q[FLAG_PERPENDICULAR];
  assign out_o.perpendicular_index = out_idx_q[FLAG_PERPENDICULAR];
  assign out_o.match_count = out_count_q;

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("An executed finish request left no result.");

  a_index_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_cnt_q <= CntLimit)
    else $error("Map plane index passed its saturation limit.");

  a_begin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && (s_op_q == OP_BEGIN)) |=> (flags_q == '0) && (map_cnt_q == '0))
    else $error("A begin request did not clear the candidate state.");

endmodule

[rtl/plane_association_matcher_core.sv]
// Matches one observed plane against a stream of map planes. A begin request loads the
// observed plane, each map plane follows as a header, its points and an end request, and
// a finish request returns one result with the best match, parallel and perpendicular
// candidates and the frame match count. Requests are taken one per cycle. The request side
// only stalls when the four-entry command queue is full, which happens only while a result
// waits at the output. Configuration must be written through the plain write port while no
// request is in flight; the block does not enforce this.
module plane_association_matcher_core #(
  parameter int MaxMapPlanes = pamc_pkg::MAX_MAP_PLANES_DEF,
  parameter int QueueDepth = pamc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pamc_in_if.sink                           in_i,
  pamc_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [pamc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pamc_pkg::WORD_W-1:0]       cfg_data_i
);
  import pamc_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.distance_limit <= WORD_W'(3277);
      cfg_q.angle_limit <= BOUND_W'(14189);
      cfg_q.perpendicular_limit <= BOUND_W'(1311);
      cfg_q.parallel_limit <= BOUND_W'(16056);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DISTANCE_LIMIT: cfg_q.distance_limit <= cfg_data_i;
        REG_ANGLE_LIMIT: cfg_q.angle_limit <= cfg_data_i[BOUND_W-1:0];
        REG_PERPENDICULAR_LIMIT: cfg_q.perpendicular_limit <= cfg_data_i[BOUND_W-1:0];
        REG_PARALLEL_LIMIT: cfg_q.parallel_limit <= cfg_data_i[BOUND_W-1:0];
      endcase
    end
  end

  pamc_front u_front (
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  pamc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_cmd)
  );

  pamc_back #(
    .MaxMapPlanes (MaxMapPlanes)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

[test/pamc_match_checker.sv]
`timescale 1ns / 1ps

module pamc_match_checker
  import pamc_pkg::*;
#(
  parameter int MaxMapPlanes = MAX_MAP_PLANES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pamc_in_if                   req_if,
  pamc_out_if                  rsp_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i,
  output int                   fail_count_o,
  output int                   reports_due_o
);

  localparam int IndexLimit = (MaxMapPlanes - 1 > 255) ? 255 : MaxMapPlanes - 1;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic             parallel_valid;
    logic [IDX_W-1:0] parallel_index;
    logic             perpendicular_valid;
    logic [IDX_W-1:0] perpendicular_index;
    logic [IDX_W-1:0] match_count;
  } match_report_t;

  logic [WORD_W-1:0]         cfg_distance;
  logic [BOUND_W-1:0]        cfg_angle;
  logic [BOUND_W-1:0]        cfg_perp;
  logic [BOUND_W-1:0]        cfg_par;
  logic signed [COEF_W-1:0]  obs_normal [3];
  logic signed [WORD_W-1:0]  obs_offset;
  logic signed [DOT_W-1:0]   map_dot;
  logic                      map_is_bad;
  logic [WORD_W-1:0]         map_min_distance;
  logic [WORD_W-1:0]         best_distance;
  logic [BOUND_W-1:0]        parallel_bound;
  logic [BOUND_W-1:0]        perpendicular_bound;
  logic [2:0]                best_flags;
  logic [IDX_W-1:0]          best_index [3];
  logic [IDX_W-1:0]          plane_index;
  logic [IDX_W-1:0]          frame_matches;
  match_report_t             match_reports_q [$];
  int                        fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] match check: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [IDX_W-1:0] seen,
                             input logic [IDX_W-1:0] want);
    if (seen !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, seen, want));
    end
  endtask

  task automatic check_report();
    match_report_t want;
    if (match_reports_q.size() == 0) begin
      report_mismatch("result arrived with no finish request pending");
      return;
    end
    want = match_reports_q.pop_front();
    check_field("found", IDX_W'(rsp_if.found), IDX_W'(want.found));
    check_field("match_index", rsp_if.match_index, want.match_index);
    check_field("parallel_valid", IDX_W'(rsp_if.parallel_valid), IDX_W'(want.parallel_valid));
    check_field("parallel_index", rsp_if.parallel_index, want.parallel_index);
    check_field("perpendicular_valid", IDX_W'(rsp_if.perpendicular_valid),
                IDX_W'(want.perpendicular_valid));
    check_field("perpendicular_index", rsp_if.perpendicular_index, want.perpendicular_index);
    check_field("match_count", rsp_if.match_count, want.match_count);
  endtask

  // Advances the matcher state by one accepted request and queues its result, if any.
  task automatic track_plane_request();
    longint        sum;
    longint        rounded;
    longint        point_distance;
    int            dot_mag;
    match_report_t rep;
    case (req_if.func)
      FUNC_BEGIN: begin
        if (req_if.new_frame) frame_matches = '0;
        obs_normal[0] = req_if.coef_a;
        obs_normal[1] = req_if.coef_b;
        obs_normal[2] = req_if.coef_c;
        obs_offset = req_if.coef_d;
        best_distance = cfg_distance;
        parallel_bound = cfg_par;
        perpendicular_bound = cfg_perp;
        best_flags = '0;
        best_index[0] = '0;
        best_index[1] = '0;
        best_index[2] = '0;
        plane_index = '0;
      end
      FUNC_HEADER: begin
        sum = longint'(req_if.coef_a) * obs_normal[0] + longint'(req_if.coef_b) * obs_normal[1]
            + longint'(req_if.coef_c) * obs_normal[2];
        rounded = (sum + ROUND_HALF) >>> FRAC_SHIFT;
        if (rounded > 65535) rounded = 65535;
        if (rounded < -65536) rounded = -65536;
        map_dot = DOT_W'(rounded);
        map_is_bad = req_if.map_bad;
        map_min_distance = DIST_START;
      end
      FUNC_POINT: begin
        if (req_if.pt_z != 0) begin
          sum = longint'(obs_normal[0]) * req_if.pt_x + longint'(obs_normal[1]) * req_if.pt_y
              + longint'(obs_normal[2]) * req_if.pt_z + longint'(obs_offset) * 16384;
          if (sum < 0) sum = -sum;
          point_distance = (sum + ROUND_HALF) >>> FRAC_SHIFT;
          if (point_distance > longint'(32'hFFFF_FFFF)) point_distance = longint'(32'hFFFF_FFFF);
          if (WORD_W'(point_distance) < map_min_distance) begin
            map_min_distance = WORD_W'(point_distance);
          end
        end
      end
      FUNC_END: begin
        if (!map_is_bad) begin
          dot_mag = int'(map_dot);
          if (dot_mag < 0) dot_mag = -dot_mag;
          if (dot_mag > int'(cfg_angle) && map_min_distance < best_distance) begin
            best_distance = map_min_distance;
            best_flags[FLAG_MATCH] = 1'b1;
            best_index[FLAG_MATCH] = plane_index;
          end else if (dot_mag > int'(parallel_bound)) begin
            parallel_bound = (dot_mag > 32767) ? BOUND_MAX : BOUND_W'(dot_mag);
            best_flags[FLAG_PARALLEL] = 1'b1;
            best_index[FLAG_PARALLEL] = plane_index;
          end else if (dot_mag < int'(perpendicular_bound)) begin
            perpendicular_bound = (dot_mag > 32767) ? BOUND_MAX : BOUND_W'(dot_mag);
            best_flags[FLAG_PERPENDICULAR] = 1'b1;
            best_index[FLAG_PERPENDICULAR] = plane_index;
          end
        end
        if (int'(plane_index) < IndexLimit) plane_index++;
      end
      FUNC_FINISH: begin
        if (best_flags[FLAG_MATCH] && frame_matches != COUNT_MAX) frame_matches++;
        rep.found = best_flags[FLAG_MATCH];
        rep.match_index = best_flags[FLAG_MATCH] ? best_index[FLAG_MATCH] : '0;
        rep.parallel_valid = best_flags[FLAG_PARALLEL];
        rep.parallel_index = best_flags[FLAG_PARALLEL] ? best_index[FLAG_PARALLEL] : '0;
        rep.perpendicular_valid = best_flags[FLAG_PERPENDICULAR];
        rep.perpendicular_index =
            best_flags[FLAG_PERPENDICULAR] ? best_index[FLAG_PERPENDICULAR] : '0;
        rep.match_count = frame_matches;
        match_reports_q.push_back(rep);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_distance = 32'd3277;
      cfg_angle = 15'd14189;
      cfg_perp = 15'd1311;
      cfg_par = 15'd16056;
      obs_normal[0] = '0;
      obs_normal[1] = '0;
      obs_normal[2] = '0;
      obs_offset = '0;
      map_dot = '0;
      map_is_bad = 1'b0;
      map_min_distance = DIST_START;
      best_distance = '0;
      parallel_bound = '0;
      perpendicular_bound = '0;
      best_flags = '0;
      best_index[0] = '0;
      best_index[1] = '0;
      best_index[2] = '0;
      plane_index = '0;
      frame_matches = '0;
      match_reports_q.delete();
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_report();
      if (req_if.valid && req_if.ready) track_plane_request();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DISTANCE_LIMIT: cfg_distance = cfg_data_i;
          REG_ANGLE_LIMIT: cfg_angle = cfg_data_i[BOUND_W-1:0];
          REG_PERPENDICULAR_LIMIT: cfg_perp = cfg_data_i[BOUND_W-1:0];
          REG_PARALLEL_LIMIT: cfg_par = cfg_data_i[BOUND_W-1:0];
          default: begin
          end
        endcase
      end
    end
    reports_due_o = match_reports_q.size();
  end

endmodule

[test/tb_plane_association_matcher_core.sv]
`timescale 1ns / 1ps

module tb_plane_association_matcher_core;
  import pamc_pkg::*;

  localparam int HoldCycles = 150;
  localparam int DrainCycles = 12;
  localparam int RandomItems = 120;
  localparam int RandomFinishes = 12;
  localparam int SegmentItems = 12;
  localparam int IdlePct [4] = '{0, 81, 0, 8};
  localparam int StallPct [4] = '{0, 0, 81, 8};

  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic                     new_frame;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [WORD_W-1:0] d;
    logic                     bad;
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
  } plane_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [WORD_W-1:0]    cfg_data;
  logic                 req_taken = 1'b0;
  int                   fail_count;
  int                   reports_due;
  int                   src_idle_pct = 0;
  int                   snk_stall_pct = 0;
  int                   hold_seq = 0;
  int                   plane_items = 0;
  int                   finish_items = 0;

  pamc_in_if  req_if ();
  pamc_out_if rsp_if ();

  plane_association_matcher_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (req_if),
    .out_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pamc_match_checker u_match_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_if        (req_if),
    .rsp_if        (rsp_if),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .reports_due_o (reports_due)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    req_taken <= req_if.valid && req_if.ready;
  end

  initial begin
    #2_000_000;
    $display("tb_plane_association_matcher_core NOT OK");
    $finish;
  end

  // The result side stalls at random, or holds off for a long stretch on request.
  initial begin : rsp_drive
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  function automatic plane_req_t rand_req(input logic [FUNC_W-1:0] func);
    plane_req_t r;
    r.func = func;
    r.new_frame = 1'($urandom_range(1));
    r.a = COEF_W'($urandom);
    r.b = COEF_W'($urandom);
    r.c = COEF_W'($urandom);
    r.d = $urandom;
    r.bad = 1'($urandom_range(1));
    r.x = $urandom;
    r.y = $urandom;
    r.z = $urandom;
    return r;
  endfunction

  function automatic plane_req_t begin_req(input int a, b, c, input logic [WORD_W-1:0] d,
                                           input logic new_frame);
    plane_req_t r;
    r = rand_req(FUNC_BEGIN);
    r.a = COEF_W'(a);
    r.b = COEF_W'(b);
    r.c = COEF_W'(c);
    r.d = d;
    r.new_frame = new_frame;
    return r;
  endfunction

  function automatic plane_req_t header_req(input int a, b, c, input logic bad);
    plane_req_t r;
    r = rand_req(FUNC_HEADER);
    r.a = COEF_W'(a);
    r.b = COEF_W'(b);
    r.c = COEF_W'(c);
    r.bad = bad;
    return r;
  endfunction

  function automatic plane_req_t point_req(input logic [WORD_W-1:0] x, y, z);
    plane_req_t r;
    r = rand_req(FUNC_POINT);
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  task automatic send_req(input plane_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.func = r.func;
    req_if.new_frame = r.new_frame;
    req_if.coef_a = r.a;
    req_if.coef_b = r.b;
    req_if.coef_c = r.c;
    req_if.coef_d = r.d;
    req_if.map_bad = r.bad;
    req_if.pt_x = r.x;
    req_if.pt_y = r.y;
    req_if.pt_z = r.z;
    req_if.valid = 1'b1;
    do @(negedge clk_i); while (!req_taken);
    if (r.func <= FUNC_FINISH) plane_items++;
    if (r.func == FUNC_FINISH) finish_items++;
  endtask

  task automatic settle();
    req_if.valid = 1'b0;
    while (reports_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_limits(input logic [WORD_W-1:0] dist_limit,
                              input logic [BOUND_W-1:0] angle,
                              input logic [BOUND_W-1:0] perp, input logic [BOUND_W-1:0] par);
    settle();
    cfg_we = 1'b1;
    cfg_idx = REG_DISTANCE_LIMIT;
    cfg_data = dist_limit;
    @(negedge clk_i);
    cfg_idx = REG_ANGLE_LIMIT;
    cfg_data = WORD_W'(angle);
    @(negedge clk_i);
    cfg_idx = REG_PERPENDICULAR_LIMIT;
    cfg_data = WORD_W'(perp);
    @(negedge clk_i);
    cfg_idx = REG_PARALLEL_LIMIT;
    cfg_data = WORD_W'(par);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // One observed plane against a few map planes, most of them close to it in angle and with
  // points lying near the observed plane, so that matches and candidates all occur.
  task automatic run_session();
    int         n [3];
    int         m [3];
    int         axis;
    int         kind;
    int         offset;
    longint     rest;
    longint     p [3];
    plane_req_t r;
    axis = $urandom_range(2);
    for (int j = 0; j < 3; j++) n[j] = int'($urandom_range(3000)) - 1500;
    n[axis] = int'($urandom_range(16384, 15000));
    if ($urandom_range(1)) n[axis] = -n[axis];
    offset = int'($urandom_range(1 << 21)) - (1 << 20);
    send_req(begin_req(n[0], n[1], n[2], offset, $urandom_range(3) == 0));
    repeat ($urandom_range(4, 1)) begin
      kind = $urandom_range(9);
      for (int j = 0; j < 3; j++) m[j] = (kind == 8) ? -n[j] : n[j];
      if (kind == 6 || kind == 7) begin
        m[0] = n[1];
        m[1] = n[2];
        m[2] = n[0];
      end
      for (int j = 0; j < 3; j++) m[j] += int'($urandom_range(600)) - 300;
      if (kind == 9) begin
        for (int j = 0; j < 3; j++) m[j] = int'($urandom_range(65535)) - 32768;
      end
      if ($urandom_range(11) != 0) send_req(header_req(m[0], m[1], m[2], $urandom_range(6) == 0));
      repeat ($urandom_range(3)) begin
        r = rand_req(FUNC_POINT);
        if ($urandom_range(7) != 0) begin
          for (int j = 0; j < 3; j++) p[j] = longint'(int'($urandom_range(1 << 20)) - (1 << 19));
          rest = longint'(offset) * 16384;
          for (int j = 0; j < 3; j++) begin
            if (j != axis) rest += longint'(n[j]) * p[j];
          end
          p[axis] = -rest / n[axis] + longint'(int'($urandom_range(8000)) - 4000);
          r.x = WORD_W'(p[0]);
          r.y = WORD_W'(p[1]);
          r.z = WORD_W'(p[2]);
          if ($urandom_range(9) == 0) r.z = '0;
        end
        send_req(r);
      end
      if ($urandom_range(14) == 0) send_req(rand_req(FUNC_W'($urandom_range(7))));
      send_req(rand_req(FUNC_END));
    end
    send_req(rand_req(FUNC_FINISH));
    if ($urandom_range(4) == 0) send_req(rand_req(FUNC_FINISH));
  endtask

  initial begin : stimulus
    int seg;
    int item_base;
    int finish_base;
    int seg_base;
    req_if.valid = 1'b0;
    req_if.func = FUNC_BEGIN;
    req_if.new_frame = 1'b0;
    req_if.coef_a = '0;
    req_if.coef_b = '0;
    req_if.coef_c = '0;
    req_if.coef_d = '0;
    req_if.map_bad = 1'b0;
    req_if.pt_x = '0;
    req_if.pt_y = '0;
    req_if.pt_z = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_DISTANCE_LIMIT;
    cfg_data = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Finish, points and end out of reset, two hand-built observed planes, unknown codes.
    send_req(rand_req(FUNC_FINISH));
    send_req(point_req($urandom, $urandom, 32'sd0));
    send_req(point_req(32'sd65536, 32'sd131072, 32'sd196608));
    send_req(rand_req(FUNC_END));
    send_req(begin_req(16384, 0, 0, 32'sd0, 1'b1));
    send_req(header_req(16384, 0, 0, 1'b0));
    send_req(point_req(32'sd1, 32'sd5, 32'sd7));
    send_req(point_req(32'sh7FFF_FFFF, -32'sd1, 32'sd0));
    send_req(rand_req(FUNC_END));
    send_req(header_req(0, 16384, 0, 1'b0));
    send_req(rand_req(FUNC_END));
    send_req(header_req(16300, 1000, 0, 1'b1));
    send_req(rand_req(FUNC_END));
    send_req(header_req(16384, 0, 0, 1'b0));
    send_req(rand_req(FUNC_END));
    send_req(header_req(-32768, -32768, -32768, 1'b0));
    send_req(point_req(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
    send_req(rand_req(FUNC_END));
    send_req(rand_req(FUNC_FINISH));
    send_req(rand_req(FUNC_FINISH));
    send_req(begin_req(-32768, -32768, -32768, 32'sh8000_0000, 1'b0));
    send_req(header_req(32767, 32767, 32767, 1'b0));
    send_req(point_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_req(rand_req(FUNC_END));
    send_req(rand_req(FUNC_FINISH));
    send_req(rand_req(3'd5));
    send_req(rand_req(3'd6));
    send_req(rand_req(3'd7));

    // Repeated finishes drive the frame match count into saturation while the result
    // side holds off, so the request queue fills and stalls the input.
    send_req(begin_req(16384, 0, 0, 32'sd0, 1'b1));
    send_req(header_req(16384, 0, 0, 1'b0));
    send_req(point_req(32'sd1, 32'sd0, 32'sd3));
    send_req(rand_req(FUNC_END));
    hold_seq++;
    repeat (258) send_req(rand_req(FUNC_FINISH));

    // More map planes than indices, so the last ones share the saturated index.
    src_idle_pct = IdlePct[3];
    snk_stall_pct = StallPct[3];
    send_req(begin_req(16384, 0, 0, 32'sd0, 1'b1));
    repeat (256) send_req(rand_req(FUNC_END));
    send_req(header_req(16384, 0, 0, 1'b0));
    send_req(point_req(32'sd0, $urandom, 32'sd5));
    send_req(rand_req(FUNC_END));
    send_req(header_req(0, 16384, 0, 1'b0));
    send_req(rand_req(FUNC_END));
    send_req(rand_req(FUNC_FINISH));

    seg = 0;
    item_base = plane_items;
    finish_base = finish_items;
    while (plane_items - item_base < RandomItems || finish_items - finish_base < RandomFinishes)
    begin
      case ((seg / 2) % 5)
        0: write_limits($urandom_range(8000, 1000), BOUND_W'($urandom_range(16000, 12000)),
                        BOUND_W'($urandom_range(4000, 500)),
                        BOUND_W'($urandom_range(16384, 15000)));
        1: write_limits('1, 15'd0, 15'd16384, 15'd0);
        2: write_limits('0, 15'd16384, 15'd0, 15'd16384);
        3: write_limits($urandom, BOUND_W'($urandom_range(16384)),
                        BOUND_W'($urandom_range(16384)), BOUND_W'($urandom_range(16384)));
        default: write_limits(32'd3277, 15'd14189, 15'd1311, 15'd16056);
      endcase
      src_idle_pct = IdlePct[seg % 4];
      snk_stall_pct = StallPct[seg % 4];
      seg_base = plane_items;
      while (plane_items - seg_base < SegmentItems) run_session();
      seg++;
    end

    src_idle_pct = 0;
    snk_stall_pct = 0;
    settle();
    if (fail_count == 0) begin
      $display("tb_plane_association_matcher_core OK");
    end else begin
      $display("tb_plane_association_matcher_core NOT OK");
    end
    $finish;
  end

endmodule
